FILE: sv/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and helpers for the polynomial evaluator
// Word formats, derivative control, step selects, the build-time exponent
// table and the saturating fixed-point multiply helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mpe_pkg;

    localparam int DEF_NUM_VARS   = 3;
    localparam int DEF_POLY_ORDER = 2;
    localparam int DEF_NUM_TERMS  = 10;

    // 1.0 in Q16.16
    localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        DERIV_NONE   = 2'd0,
        DERIV_FIRST  = 2'd1,
        DERIV_SECOND = 2'd2,
        DERIV_UNUSED = 2'd3
    } deriv_order_t;

    // which coordinate a monomial step multiplies by
    typedef enum logic [1:0] {
        SEL_X    = 2'd0,
        SEL_Y    = 2'd1,
        SEL_Z    = 2'd2,
        SEL_NONE = 2'd3
    } step_sel_t;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [1:0]         deriv_order;
        logic [1:0]         var_a;
        logic [1:0]         var_b;
    } mpe_in_t;

    typedef struct packed {
        logic signed [63:0] poly_value;
        logic               overflow;
    } mpe_out_t;

    // derivative control shared by all term lanes
    typedef struct packed {
        logic            kill;   // no term contributes
        logic [2:0][1:0] cnt;    // differentiation count per variable
    } deriv_ctl_t;

    // exponents {e2, e1, e0} of term t, descending lexicographic order
    function automatic logic [8:0] term_exp(int nv, int ord, int t);
        int lim0, lim1, lim2, n;
        logic [8:0] r;
        lim0 = (nv > 0) ? ord : 0;
        lim1 = (nv > 1) ? ord : 0;
        lim2 = (nv > 2) ? ord : 0;
        n = 0;
        r = '0;
        for (int a = lim0; a >= 0; a--) begin
            for (int b = lim1; b >= 0; b--) begin
                for (int c = lim2; c >= 0; c--) begin
                    if (a + b + c <= ord) begin
                        if (n == t) begin
                            r = {3'(c), 3'(b), 3'(a)};
                        end
                        n++;
                    end
                end
            end
        end
        return r;
    endfunction

    // number of complete terms
    function automatic int term_total(int nv, int ord);
        int lim0, lim1, lim2, n;
        lim0 = (nv > 0) ? ord : 0;
        lim1 = (nv > 1) ? ord : 0;
        lim2 = (nv > 2) ? ord : 0;
        n = 0;
        for (int a = lim0; a >= 0; a--) begin
            for (int b = lim1; b >= 0; b--) begin
                for (int c = lim2; c >= 0; c--) begin
                    if (a + b + c <= ord) begin
                        n++;
                    end
                end
            end
        end
        return n;
    endfunction

    // Q16.16 product, floor shift, saturate to 32 bits: {sat, value}
    function automatic logic [32:0] q16_mul_sat(logic signed [31:0] a,
                                                logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] s;
        logic [32:0]        r;
        p = a * b;
        s = p[63:16];
        if (s[47:31] == '0 || s[47:31] == '1) begin
            r = {1'b0, s[31:0]};
        end else if (s[47]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        return r;
    endfunction

    // integer derivative factor times monomial, saturated: {sat, value}
    function automatic logic [32:0] fac_mul_sat(logic signed [31:0] a, logic [3:0] f);
        logic signed [4:0]  fs;
        logic signed [36:0] p;
        logic [32:0]        r;
        fs = {1'b0, f};
        p = a * fs;
        if (p[36:31] == '0 || p[36:31] == '1) begin
            r = {1'b0, p[31:0]};
        end else if (p[36]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/multivar_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// multivar_polynomial_evaluator: streaming multivariate polynomial evaluator
// Load words write coefficients; evaluate words return the value or a first
// or second partial derivative at a point, as a Q48.16 sum.
// ----------------------------------------------------------------------------
// A new word is taken every cycle while the result side keeps up. An
// evaluate word passes through one input register, one saturating
// multiply stage per unit of order in each term lane, a derivative factor
// stage, a coefficient stage, the adder tree (always at least one level)
// and the output register. Load words give no result and write their
// coefficient as they pass the coefficient stage, so words keep their
// order. A stall on the result side holds the whole pipeline.
`default_nettype none

module multivar_polynomial_evaluator #(
    parameter int NUM_VARS   = mpe_pkg::DEF_NUM_VARS,
    parameter int POLY_ORDER = mpe_pkg::DEF_POLY_ORDER,
    parameter int NUM_TERMS  = mpe_pkg::DEF_NUM_TERMS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mpe_pkg::mpe_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mpe_pkg::mpe_out_t     m_data
);
    import mpe_pkg::*;

    localparam int LD_STG = POLY_ORDER + 1;

    logic     en;
    logic     m_valid_reg;
    mpe_out_t m_data_reg;

    // item pipeline up to the coefficient stage
    mpe_in_t item_reg [LD_STG+1];
    logic    vld_reg  [LD_STG+1];
    logic    eval_vld_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LD_STG; k++) begin
                vld_reg[k] <= 1'b0;
            end
            eval_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= LD_STG; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            eval_vld_reg <= vld_reg[LD_STG] && (item_reg[LD_STG].req_type == REQ_EVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= s_data;
            for (int k = 1; k <= LD_STG; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
        end
    end

    // derivative decode
    deriv_ctl_t ctl;

    always_comb begin
        logic [1:0] ord, va, vb;
        ord = item_reg[0].deriv_order;
        va  = item_reg[0].var_a;
        vb  = item_reg[0].var_b;
        for (int v = 0; v < 3; v++) begin
            ctl.cnt[v] = 2'({1'b0, (ord == DERIV_FIRST || ord == DERIV_SECOND) && va == 2'(v)})
                       + 2'({1'b0, ord == DERIV_SECOND && vb == 2'(v)});
        end
        ctl.kill = (ord == DERIV_UNUSED)
                || ((ord == DERIV_FIRST || ord == DERIV_SECOND) && 32'(va) >= NUM_VARS)
                || (ord == DERIV_SECOND && 32'(vb) >= NUM_VARS);
    end

    // coordinates seen by each monomial stage
    logic [POLY_ORDER-1:0][2:0][31:0] coord_pipe;

    always_comb begin
        for (int k = 0; k < POLY_ORDER; k++) begin
            coord_pipe[k][0] = item_reg[k].coord_x;
            coord_pipe[k][1] = item_reg[k].coord_y;
            coord_pipe[k][2] = item_reg[k].coord_z;
        end
    end

    logic signed [63:0] term_value [NUM_TERMS];
    logic               term_ovf   [NUM_TERMS];

    for (genvar t = 0; t < NUM_TERMS; t++) begin : g_lane
        logic wr_en;
        assign wr_en = vld_reg[LD_STG] && (item_reg[LD_STG].req_type == REQ_LOAD)
                    && (32'(item_reg[LD_STG].coef_index) == t);

        mpe_term_lane #(
            .NUM_VARS   (NUM_VARS),
            .POLY_ORDER (POLY_ORDER),
            .TERM_IDX   (t)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctl        (ctl),
            .coord_pipe (coord_pipe),
            .wr_en      (wr_en),
            .wr_value   (item_reg[LD_STG].coef_value),
            .term_value (term_value[t]),
            .term_ovf   (term_ovf[t])
        );
    end

    logic               sum_vld;
    logic signed [63:0] sum_value;
    logic               sum_ovf;

    mpe_adder_tree #(
        .NUM_TERMS (NUM_TERMS)
    ) u_tree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (eval_vld_reg),
        .terms   (term_value),
        .ovfs    (term_ovf),
        .out_vld (sum_vld),
        .out_sum (sum_value),
        .out_ovf (sum_ovf)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sum_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.poly_value <= sum_value;
            m_data_reg.overflow   <= sum_ovf;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sv/mpe_term_lane.sv
// ----------------------------------------------------------------------------
// mpe_term_lane: one polynomial term
// Plans the monomial steps from the derivative control, runs one saturating
// multiply per stage, applies the derivative factor, then the coefficient.
// Holds the term's coefficient register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_term_lane #(
    parameter int NUM_VARS   = 3,
    parameter int POLY_ORDER = 2,
    parameter int TERM_IDX   = 0
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire mpe_pkg::deriv_ctl_t                  ctl,
    input  wire logic [POLY_ORDER-1:0][2:0][31:0]     coord_pipe,
    input  wire logic                                 wr_en,
    input  wire logic signed [31:0]                   wr_value,
    output logic signed [63:0]                        term_value,
    output logic                                      term_ovf
);
    import mpe_pkg::*;

    localparam logic [8:0] EXPS   = term_exp(NUM_VARS, POLY_ORDER, TERM_IDX);
    localparam bit         EXISTS = (TERM_IDX < term_total(NUM_VARS, POLY_ORDER));

    typedef step_sel_t [POLY_ORDER-1:0] sel_vec_t;

    // stage nodes: index 0 is the plan, j is the output of stage j
    logic signed [31:0] mono_n [POLY_ORDER+1];
    sel_vec_t           sel_n  [POLY_ORDER+1];
    logic               live_n [POLY_ORDER+1];
    logic [3:0]         fac_n  [POLY_ORDER+1];
    logic               ovf_n  [POLY_ORDER+1];

    // step plan from exponents and derivative counts
    always_comb begin
        logic       zfound;
        logic [2:0] e;
        logic [2:0] d0, d1, d2, dv;
        logic [3:0] lim0, lim1, lim2;
        logic [3:0] fac;
        zfound = 1'b0;
        d0 = '0;
        d1 = '0;
        d2 = '0;
        fac = 4'd1;
        for (int v = 0; v < 3; v++) begin
            e = EXPS[3*v +: 3];
            dv = '0;
            if (!zfound) begin
                if (e < 3'(ctl.cnt[v])) begin
                    zfound = 1'b1;
                end else begin
                    dv = e - 3'(ctl.cnt[v]);
                    if (ctl.cnt[v] != 2'd0) begin
                        fac = 4'(fac * {1'b0, e});
                    end
                    if (ctl.cnt[v] == 2'd2) begin
                        fac = 4'(fac * {1'b0, e - 3'd1});
                    end
                end
            end
            unique case (v)
                0:       d0 = dv;
                1:       d1 = dv;
                default: d2 = dv;
            endcase
        end
        if (ctl.kill || !EXISTS) begin
            d0 = '0;
            d1 = '0;
            d2 = '0;
        end
        live_n[0] = !ctl.kill && EXISTS && !zfound;
        fac_n[0]  = fac;
        lim0 = {1'b0, d0};
        lim1 = lim0 + {1'b0, d1};
        lim2 = lim1 + {1'b0, d2};
        for (int j = 0; j < POLY_ORDER; j++) begin
            if (4'(j) < lim0) begin
                sel_n[0][j] = SEL_X;
            end else if (4'(j) < lim1) begin
                sel_n[0][j] = SEL_Y;
            end else if (4'(j) < lim2) begin
                sel_n[0][j] = SEL_Z;
            end else begin
                sel_n[0][j] = SEL_NONE;
            end
        end
    end

    assign mono_n[0] = Q16_ONE;
    assign ovf_n[0]  = 1'b0;

    // one monomial multiply per stage
    for (genvar j = 1; j <= POLY_ORDER; j++) begin : g_step
        logic signed [31:0] mono_reg, mono_next;
        sel_vec_t           sel_reg;
        logic               live_reg;
        logic [3:0]         fac_reg;
        logic               ovf_reg, ovf_next;

        always_comb begin
            logic [32:0]        r;
            logic signed [31:0] c;
            c = $signed(coord_pipe[j-1][0]);
            unique case (sel_n[j-1][j-1])
                SEL_X:   c = $signed(coord_pipe[j-1][0]);
                SEL_Y:   c = $signed(coord_pipe[j-1][1]);
                SEL_Z:   c = $signed(coord_pipe[j-1][2]);
                default: c = Q16_ONE;
            endcase
            r = q16_mul_sat(mono_n[j-1], c);
            if (sel_n[j-1][j-1] == SEL_NONE) begin
                mono_next = mono_n[j-1];
                ovf_next  = ovf_n[j-1];
            end else begin
                mono_next = r[31:0];
                ovf_next  = ovf_n[j-1] | r[32];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mono_reg <= mono_next;
                ovf_reg  <= ovf_next;
                sel_reg  <= sel_n[j-1];
                live_reg <= live_n[j-1];
                fac_reg  <= fac_n[j-1];
            end
        end

        assign mono_n[j] = mono_reg;
        assign ovf_n[j]  = ovf_reg;
        assign sel_n[j]  = sel_reg;
        assign live_n[j] = live_reg;
        assign fac_n[j]  = fac_reg;
    end

    // derivative factor stage
    logic signed [31:0] fmono_reg;
    logic               fovf_reg;
    logic               flive_reg;

    always_ff @(posedge aclk) begin
        logic [32:0] r;
        r = fac_mul_sat(mono_n[POLY_ORDER], fac_n[POLY_ORDER]);
        if (en) begin
            flive_reg <= live_n[POLY_ORDER];
            if (live_n[POLY_ORDER]) begin
                fmono_reg <= r[31:0];
                fovf_reg  <= ovf_n[POLY_ORDER] | r[32];
            end else begin
                fmono_reg <= '0;
                fovf_reg  <= ovf_n[POLY_ORDER];
            end
        end
    end

    // coefficient register, written by a load word at the factor stage
    logic signed [31:0] coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (en && wr_en) begin
            coef_reg <= wr_value;
        end
    end

    // coefficient stage: Q48.16 term, floor shift, no saturation
    logic signed [63:0] term_reg;
    logic               tovf_reg;

    always_ff @(posedge aclk) begin
        logic signed [63:0] p;
        p = fmono_reg * coef_reg;
        if (en) begin
            term_reg <= flive_reg ? {{16{p[63]}}, p[63:16]} : 64'sd0;
            tovf_reg <= fovf_reg;
        end
    end

    assign term_value = term_reg;
    assign term_ovf   = tovf_reg;

endmodule

`default_nettype wire

FILE: sv/mpe_adder_tree.sv
// ----------------------------------------------------------------------------
// mpe_adder_tree: registered pairwise sum of the term values
// One adder level per stage. Terms are bounded well below the 64-bit range,
// so the sum cannot wrap. Saturation flags are ORed alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_adder_tree #(
    parameter int NUM_TERMS = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic signed [63:0] terms [NUM_TERMS],
    input  wire logic               ovfs  [NUM_TERMS],
    output logic                    out_vld,
    output logic signed [63:0]      out_sum,
    output logic                    out_ovf
);
    localparam int LEVELS = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    logic signed [63:0] node_sum [LEVELS+1][NUM_TERMS];
    logic               node_ovf [LEVELS+1][NUM_TERMS];
    logic               node_vld [LEVELS+1];

    for (genvar i = 0; i < NUM_TERMS; i++) begin : g_leaf
        assign node_sum[0][i] = terms[i];
        assign node_ovf[0][i] = ovfs[i];
    end
    assign node_vld[0] = in_vld;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int NP = (NUM_TERMS + (1 << l) - 1) >> l;
        localparam int NL = (NUM_TERMS + (1 << (l + 1)) - 1) >> (l + 1);
        logic vld_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= node_vld[l];
            end
        end
        assign node_vld[l+1] = vld_reg;

        for (genvar i = 0; i < NUM_TERMS; i++) begin : g_node
            if (i < NL) begin : g_add
                logic signed [63:0] sum_reg;
                logic               ovf_reg;
                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (2*i + 1 < NP) begin
                            sum_reg <= node_sum[l][2*i] + node_sum[l][2*i+1];
                            ovf_reg <= node_ovf[l][2*i] | node_ovf[l][2*i+1];
                        end else begin
                            sum_reg <= node_sum[l][2*i];
                            ovf_reg <= node_ovf[l][2*i];
                        end
                    end
                end
                assign node_sum[l+1][i] = sum_reg;
                assign node_ovf[l+1][i] = ovf_reg;
            end else begin : g_pad
                assign node_sum[l+1][i] = '0;
                assign node_ovf[l+1][i] = 1'b0;
            end
        end
    end

    assign out_vld = node_vld[LEVELS];
    assign out_sum = node_sum[LEVELS][0];
    assign out_ovf = node_ovf[LEVELS][0];

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for multivar_polynomial_evaluator
// Drives coefficient loads and evaluate words through the valid/ready input,
// predicts each evaluate result with a local fixed-point model of the term
// table and the saturating arithmetic, and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import mpe_pkg::*;

    localparam int NVARS  = 3;
    localparam int ORDER  = 2;
    localparam int NTERMS = 10;
    localparam int LATENCY = 9;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mpe_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mpe_out_t m_data;

    multivar_polynomial_evaluator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    int              exps [NTERMS][3];
    logic signed [31:0] coefs [NTERMS];
    mpe_out_t        pending_results [$];
    int              error_count = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              recv_hold = 1'b0;

    // build the exponent table, first variable descending slowest
    task automatic build_exponents();
        int n;
        n = 0;
        for (int a = ORDER; a >= 0; a--)
            for (int b = ORDER; b >= 0; b--)
                for (int c = ORDER; c >= 0; c--)
                    if (a + b + c <= ORDER && n < NTERMS) begin
                        exps[n][0] = a;
                        exps[n][1] = b;
                        exps[n][2] = c;
                        n++;
                    end
    endtask

    function automatic longint floor16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // value or partial derivative of the loaded polynomial at a point
    function automatic mpe_out_t evaluate_poly(mpe_in_t w);
        longint  pt [3];
        int      cnt [3];
        longint  sum, mono, fac, term;
        bit      sat, dead, zero;
        longint  r;
        mpe_out_t res;
        pt[0] = w.coord_x;
        pt[1] = w.coord_y;
        pt[2] = w.coord_z;
        cnt = '{0, 0, 0};
        sum = 0;
        sat = 1'b0;
        if (w.deriv_order != DERIV_UNUSED) begin
            if (w.deriv_order != DERIV_NONE && w.var_a < 3) cnt[w.var_a]++;
            if (w.deriv_order == DERIV_SECOND && w.var_b < 3) cnt[w.var_b]++;
            dead = (w.deriv_order != DERIV_NONE && w.var_a >= NVARS) ||
                   (w.deriv_order == DERIV_SECOND && w.var_b >= NVARS);
            for (int t = 0; t < NTERMS && !dead; t++) begin
                mono = 65536;
                fac = 1;
                zero = 1'b0;
                for (int v = 0; v < 3; v++) begin
                    if (exps[t][v] < cnt[v]) begin
                        zero = 1'b1;
                        break;
                    end
                    if (cnt[v] >= 1) fac *= exps[t][v];
                    if (cnt[v] == 2) fac *= exps[t][v] - 1;
                    for (int k = 0; k < exps[t][v] - cnt[v]; k++)
                        mono = clamp32(floor16(mono * pt[v]), sat);
                end
                if (zero) continue;
                mono = clamp32(mono * fac, sat);
                term = floor16(mono * longint'(coefs[t]));
                r = sum + term;
                // signed 64-bit saturation
                if (term > 0 && sum > 0 && r < 0) begin
                    sat = 1'b1;
                    r = 64'h7FFF_FFFF_FFFF_FFFF;
                end else if (term < 0 && sum < 0 && r >= 0) begin
                    sat = 1'b1;
                    r = 64'h8000_0000_0000_0000;
                end
                sum = r;
            end
        end
        res.poly_value = sum;
        res.overflow = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // send one word, predicting its result when accepted
    task automatic send_word(mpe_in_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.req_type == REQ_LOAD) begin
            if (w.coef_index < NTERMS) coefs[w.coef_index] = w.coef_value;
        end else begin
            pending_results.push_back(evaluate_poly(w));
        end
        @(negedge aclk);
    endtask

    // receiver ready pattern
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready <= !recv_hold && !(recv_idle_pct > 0 &&
                       $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    initial begin
        mpe_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", m_data.poly_value, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.poly_value !== want.poly_value)
                        report_mismatch("poly_value", m_data.poly_value, want.poly_value);
                    if (m_data.overflow !== want.overflow)
                        report_mismatch("overflow", longint'(m_data.overflow),
                                        longint'(want.overflow));
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic mpe_in_t rand_word();
        logic [159:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return rnd[$bits(mpe_in_t)-1:0];
    endfunction

    function automatic mpe_in_t make_load(int idx, logic signed [31:0] val);
        mpe_in_t w;
        w = rand_word();
        w.req_type = REQ_LOAD;
        w.coef_index = 4'(idx);
        w.coef_value = val;
        return w;
    endfunction

    function automatic mpe_in_t make_eval(int ord, int va, int vb);
        mpe_in_t w;
        w = rand_word();
        w.req_type = REQ_EVAL;
        w.coord_x = rand_coord();
        w.coord_y = rand_coord();
        w.coord_z = rand_coord();
        w.deriv_order = 2'(ord);
        w.var_a = 2'(va);
        w.var_b = 2'(vb);
        return w;
    endfunction

    // extremes, every derivative mode, out-of-range cases
    task automatic test_directed();
        mpe_in_t w;
        send_word(make_eval(DERIV_NONE, 0, 0));         // all-zero store
        for (int i = 0; i < NTERMS; i++) send_word(make_load(i, 32'sh0001_0000));
        send_word(make_load(15, 32'sh7FFF_FFFF));       // index out of range
        w = make_eval(DERIV_NONE, 0, 0);
        w.coord_x = 32'sh7FFF_FFFF; w.coord_y = 32'sh7FFF_FFFF; w.coord_z = 32'sh8000_0000;
        send_word(w);
        send_word(make_eval(DERIV_FIRST, 0, 0));
        send_word(make_eval(DERIV_FIRST, 2, 1));
        send_word(make_eval(DERIV_SECOND, 1, 1));
        send_word(make_eval(DERIV_SECOND, 0, 2));
        send_word(make_eval(DERIV_FIRST, 3, 0));         // variable out of range
        send_word(make_eval(DERIV_SECOND, 0, 3));
        send_word(make_eval(DERIV_UNUSED, 1, 1));
        send_word(make_load(0, 32'sh8000_0000));
        send_word(make_load(9, 32'sh7FFF_FFFF));
        w = make_eval(DERIV_NONE, 0, 0);
        w.coord_x = 32'sh8000_0000;
        send_word(w);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0)
                send_word(make_load($urandom_range(15), $urandom));
            else
                send_word(make_eval($urandom_range(3), $urandom_range(3), $urandom_range(3)));
        end
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (60) @(posedge aclk);
                recv_hold = 1'b0;
            end
            test_random(40);
        join
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    initial begin
        build_exponents();
        for (int i = 0; i < NTERMS; i++) coefs[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        send_idle_pct = 13; recv_idle_pct = 82;
        test_random(550);
        send_idle_pct = 82; recv_idle_pct = 13;
        test_random(550);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(550);
        drain();
        if (error_count == 0)
            $display("** multivar_polynomial_evaluator: PASSED **");
        else
            $display("** multivar_polynomial_evaluator: FAILED **");
        $finish;
    end

    initial begin
        #4000000;
        $display("** multivar_polynomial_evaluator: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
